@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define GHI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define GHI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ghi_pkg.sv @@
// shared types and constants of the gyro heading integrator
`timescale 1ns / 1ps

package ghi_pkg;

    // defaults and widths
    localparam int CAL_LOG2_DEF   = 8;
    localparam int SUM_W          = 25;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd10;
    localparam logic [9:0]  MAX_DT_RST       = 10'd1000;

    // one full turn in heading units (1/33536000 degree)
    localparam logic [33:0] FULL_TURN = 34'd12072960000;

    // input function codes
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_ZERO   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_MIN_INTERVAL = 1'b0;
    localparam logic CFG_MAX_DT       = 1'b1;

    // classified command
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_ZERO   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // heading operation handed from the control stage to the accumulator
    typedef enum logic [1:0] {
        HOP_KEEP  = 2'b00,
        HOP_CLEAR = 2'b01,
        HOP_ADD   = 2'b10
    } t_hop;

    // one classified item
    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] raw;
        logic [31:0]        time_ms;
    } t_item;

    // configuration registers
    typedef struct packed {
        logic [15:0] min_interval;
        logic [9:0]  max_dt;
    } t_cfg;

endpackage

@@ sv/ghi_front.sv @@
// front end: accepts input beats, classifies the function code and registers the item
`timescale 1ns / 1ps

module ghi_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_func,
    input  logic signed [15:0]  i_raw_rate,
    input  logic [31:0]         i_time_ms,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output ghi_pkg::t_item      o_item
);

    logic           r_valid;
    logic           n_valid;
    ghi_pkg::t_item r_item;
    ghi_pkg::t_cmd  w_cmd;
    logic           w_load;

    // map the raw function code onto a command
    always_comb begin
        unique case (i_func)
            ghi_pkg::FUNC_SAMPLE: w_cmd = ghi_pkg::CMD_SAMPLE;
            ghi_pkg::FUNC_START:  w_cmd = ghi_pkg::CMD_START;
            ghi_pkg::FUNC_ZERO:   w_cmd = ghi_pkg::CMD_ZERO;
            ghi_pkg::FUNC_UNUSED: w_cmd = ghi_pkg::CMD_NOP;
        endcase
    end

    // input stage handshake
    assign o_in_ready   = !r_valid || i_item_ready;
    assign w_load       = i_in_valid && o_in_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_item_ready) begin
            n_valid = 1'b0;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd     <= w_cmd;
            r_item.raw     <= i_raw_rate;
            r_item.time_ms <= i_time_ms;
        end
    end

endmodule

@@ sv/ghi_queue.sv @@
// short item queue between the front end and the execution back end
`timescale 1ns / 1ps

module ghi_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  ghi_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_pop_valid,
    output ghi_pkg::t_item o_item
);

    localparam int DEPTH = ghi_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ghi_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_item       = r_mem[r_rd];
    assign w_wr_en      = i_push && o_push_ready;
    assign w_rd_en      = i_pop && o_pop_valid;

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wr_en) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ sv/ghi_back.sv @@
// back end: calibration and timing control, rate multiply, heading accumulate and wrap
`timescale 1ns / 1ps

module ghi_back #(
    parameter int CAL_LOG2 = ghi_pkg::CAL_LOG2_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ghi_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  ghi_pkg::t_item      i_q_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [33:0]         o_heading,
    output logic signed [25:0]  o_corrected_rate,
    output logic                o_calibrating,
    output logic                o_enabled,
    output logic                o_integrated
);

    localparam int SUM_W   = ghi_pkg::SUM_W;
    localparam int CNT_W   = CAL_LOG2 + 1;
    localparam int BIAS_SH = 8 - CAL_LOG2;
    localparam logic [CNT_W-1:0] CAL_SAMPLES = CNT_W'(1) << CAL_LOG2;
    localparam logic signed [37:0] TURN     = $signed({4'b0, ghi_pkg::FULL_TURN});
    localparam logic signed [37:0] TWO_TURN = TURN + TURN;

    // control state
    logic                    r_enabled,  n_enabled;
    logic                    r_cal,      n_cal;
    logic [CNT_W-1:0]        r_count,    n_count;
    logic signed [SUM_W-1:0] r_sum,      n_sum;
    logic signed [SUM_W-1:0] r_bias,     n_bias;
    logic [31:0]             r_last,     n_last;

    // control stage register
    logic                    r_a_valid,  n_a_valid;
    ghi_pkg::t_hop           r_a_hop,    n_a_hop;
    logic signed [36:0]      r_a_prod;
    logic signed [25:0]      r_a_corr;
    logic                    r_a_cal;
    logic                    r_a_en;
    logic                    r_a_int,    n_a_int;

    // output register and heading state
    logic                    r_o_valid,  n_o_valid;
    logic signed [25:0]      r_o_corr;
    logic                    r_o_cal;
    logic                    r_o_en;
    logic                    r_o_int;
    logic [33:0]             r_heading,  n_heading;

    logic                    w_out_free;
    logic                    w_a_move;
    logic signed [25:0]      w_corr;
    logic [31:0]             w_elapsed;
    logic [9:0]              w_dt;
    logic signed [36:0]      w_prod;
    logic [CNT_W-1:0]        w_count_inc;
    logic signed [SUM_W-1:0] w_sum_inc;
    logic signed [37:0]      w_hsum;
    logic [33:0]             w_wrapped;

    // pipeline handshake
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_a_move   = r_a_valid && w_out_free;
    assign o_q_pop    = i_q_valid && (!r_a_valid || w_out_free);

    // corrected rate against the bias held before this item
    assign w_corr = {{2{i_q_item.raw[15]}}, i_q_item.raw, 8'b0} - {r_bias[SUM_W-1], r_bias};

    // elapsed time, saturated step and rate product
    assign w_elapsed = i_q_item.time_ms - r_last;
    assign w_dt      = (w_elapsed < {22'b0, i_cfg.max_dt}) ? w_elapsed[9:0] : i_cfg.max_dt;
    assign w_prod    = $signed({{11{w_corr[25]}}, w_corr}) * $signed({27'b0, w_dt});

    // calibration accumulate
    assign w_count_inc = r_count + 1'b1;
    assign w_sum_inc   = r_sum + {{(SUM_W-16){i_q_item.raw[15]}}, i_q_item.raw};

    // command execution
    always_comb begin
        n_enabled = r_enabled;
        n_cal     = r_cal;
        n_count   = r_count;
        n_sum     = r_sum;
        n_bias    = r_bias;
        n_last    = r_last;
        n_a_hop   = ghi_pkg::HOP_KEEP;
        n_a_int   = 1'b0;
        if (o_q_pop) begin
            unique case (i_q_item.cmd)
                ghi_pkg::CMD_START: begin
                    n_enabled = 1'b1;
                    n_last    = i_q_item.time_ms;
                    n_cal     = 1'b1;
                    n_count   = '0;
                    n_sum     = '0;
                end
                ghi_pkg::CMD_ZERO: begin
                    n_a_hop = ghi_pkg::HOP_CLEAR;
                end
                ghi_pkg::CMD_SAMPLE: begin
                    if (r_enabled) begin
                        if (r_cal) begin
                            n_count = w_count_inc;
                            n_sum   = w_sum_inc;
                            if (w_count_inc == CAL_SAMPLES) begin
                                n_bias  = w_sum_inc <<< BIAS_SH;
                                n_a_hop = ghi_pkg::HOP_CLEAR;
                                n_cal   = 1'b0;
                                n_count = '0;
                                n_sum   = '0;
                            end
                        end else if (w_elapsed >= {16'b0, i_cfg.min_interval}) begin
                            n_a_hop = ghi_pkg::HOP_ADD;
                            n_last  = i_q_item.time_ms;
                            n_a_int = 1'b1;
                        end
                    end
                end
                ghi_pkg::CMD_NOP: begin
                end
            endcase
        end
    end

    // heading add and wrap into one turn
    assign w_hsum = $signed({4'b0, r_heading}) + {r_a_prod[36], r_a_prod};

    always_comb begin
        priority if (w_hsum < -TURN) begin
            w_wrapped = 34'(w_hsum + TWO_TURN);
        end else if (w_hsum < 38'sd0) begin
            w_wrapped = 34'(w_hsum + TURN);
        end else if (w_hsum < TURN) begin
            w_wrapped = 34'(w_hsum);
        end else if (w_hsum < TWO_TURN) begin
            w_wrapped = 34'(w_hsum - TURN);
        end else begin
            w_wrapped = 34'(w_hsum - TWO_TURN);
        end
    end

    always_comb begin
        n_heading = r_heading;
        if (w_a_move) begin
            unique case (r_a_hop)
                ghi_pkg::HOP_CLEAR: n_heading = '0;
                ghi_pkg::HOP_ADD:   n_heading = w_wrapped;
                default:            n_heading = r_heading;
            endcase
        end
    end

    // stage valid bits
    always_comb begin
        n_a_valid = r_a_valid;
        if (o_q_pop) begin
            n_a_valid = 1'b1;
        end else if (w_out_free) begin
            n_a_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (w_a_move) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end
    end

    // control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_cal     <= 1'b0;
            r_count   <= '0;
            r_sum     <= '0;
            r_bias    <= '0;
            r_last    <= '0;
            r_heading <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_enabled <= n_enabled;
            r_cal     <= n_cal;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_bias    <= n_bias;
            r_last    <= n_last;
            r_heading <= n_heading;
            r_a_valid <= n_a_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // control stage payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_hop  <= n_a_hop;
            r_a_prod <= w_prod;
            r_a_corr <= w_corr;
            r_a_cal  <= n_cal;
            r_a_en   <= n_enabled;
            r_a_int  <= n_a_int;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_o_corr <= r_a_corr;
            r_o_cal  <= r_a_cal;
            r_o_en   <= r_a_en;
            r_o_int  <= r_a_int;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_heading        = r_heading;
    assign o_corrected_rate = r_o_corr;
    assign o_calibrating    = r_o_cal;
    assign o_enabled        = r_o_en;
    assign o_integrated     = r_o_int;

endmodule

@@ sv/gyro_heading_integrator.sv @@
// top level of the gyro heading integrator: config registers and front, queue, back
`timescale 1ns / 1ps
//
// Gyro bias calibration and heading integration.
// Input channel (i_in_valid / o_in_ready) carries one beat per sample or command:
// i_func (0 rate sample, 1 start calibration, 2 zero heading), i_raw_rate, i_time_ms.
// Output channel (o_out_valid / i_out_ready) returns exactly one beat per input beat,
// in order: heading, corrected rate, calibration and enable flags, integrated flag.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata while idle:
// index 0 is the minimum sample interval, index 1 the saturation of the time step.
// A beat passes the input register, queue, control stage and output register.
// Throughput: one beat per cycle unless stalled; the heading accumulator with its add
// and turn wrap closes in a single cycle, behind a registered rate multiply.
// A 2-entry queue separates the input register from the execution stages, so input
// keeps flowing while a finished result waits in the output register.
// When the receiver stalls, the output register holds, then the execution stages,
// then the queue fills and o_in_ready drops.
// Reset (synchronous, active low) clears the pipeline, disables the block, zeroes
// bias and heading, and restores the config defaults (10 ms, 1000 ms).
//

module gyro_heading_integrator #(
    parameter int CAL_LOG2 = ghi_pkg::CAL_LOG2_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_func,
    input  logic signed [15:0]  i_raw_rate,
    input  logic [31:0]         i_time_ms,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [33:0]         o_heading,
    output logic signed [25:0]  o_corrected_rate,
    output logic                o_calibrating,
    output logic                o_enabled,
    output logic                o_integrated,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [15:0]         i_cfg_wdata
);

    ghi_pkg::t_cfg  r_cfg;
    ghi_pkg::t_item w_front_item;
    ghi_pkg::t_item w_q_item;
    logic           w_front_valid;
    logic           w_q_ready;
    logic           w_q_valid;
    logic           w_q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval <= ghi_pkg::MIN_INTERVAL_RST;
            r_cfg.max_dt       <= ghi_pkg::MAX_DT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == ghi_pkg::CFG_MIN_INTERVAL) begin
                r_cfg.min_interval <= i_cfg_wdata;
            end
            if (i_cfg_addr == ghi_pkg::CFG_MAX_DT) begin
                r_cfg.max_dt <= i_cfg_wdata[9:0];
            end
        end
    end

    // input register and classification
    ghi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_raw_rate   (i_raw_rate),
        .i_time_ms    (i_time_ms),
        .o_item_valid (w_front_valid),
        .i_item_ready (w_q_ready),
        .o_item       (w_front_item)
    );

    // decoupling queue
    ghi_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_front_valid),
        .o_push_ready (w_q_ready),
        .i_item       (w_front_item),
        .i_pop        (w_q_pop),
        .o_pop_valid  (w_q_valid),
        .o_item       (w_q_item)
    );

    // execution
    ghi_back #(
        .CAL_LOG2 (CAL_LOG2)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (w_q_valid),
        .o_q_pop          (w_q_pop),
        .i_q_item         (w_q_item),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_heading        (o_heading),
        .o_corrected_rate (o_corrected_rate),
        .o_calibrating    (o_calibrating),
        .o_enabled        (o_enabled),
        .o_integrated     (o_integrated)
    );

endmodule

@@ sv/ghi_checker.sv @@
// port-level checker for the gyro heading integrator and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghi_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [33:0]         o_heading,
    input  logic                o_calibrating,
    input  logic                o_enabled,
    input  logic                o_integrated
);

    // no result beat right after reset
    `GHI_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a stalled result beat holds its heading
    `GHI_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_heading), "stalled result changed")

    // heading stays within one turn
    `GHI_ASSERT(a_heading_range, i_clk, i_rst_n, o_out_valid |-> o_heading < ghi_pkg::FULL_TURN, "heading outside one turn")

    // integration only when enabled and calibration is done
    `GHI_ASSERT(a_integrated_state, i_clk, i_rst_n, o_out_valid && o_integrated |-> o_enabled && !o_calibrating, "integrated in wrong state")

    // calibration never runs while disabled
    `GHI_ASSERT(a_cal_enabled, i_clk, i_rst_n, o_out_valid && o_calibrating |-> o_enabled, "calibrating while disabled")

endmodule

bind gyro_heading_integrator ghi_checker u_ghi_checker (.*);

@@ verif/tb.sv @@
// self-checking testbench for the gyro heading integrator
`timescale 1ns / 1ps

module tb;
    import ghi_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int CAL_SAMPLES = 1 << CAL_LOG2_DEF;
    localparam logic [31:0] CAL_BASE_MS = 32'd50000;

    typedef enum {FILL_NONE, FILL_MAX, FILL_MIN, FILL_RANDOM} t_cal_fill;

    typedef struct {
        logic [33:0]        heading;
        logic signed [25:0] rate;
        logic               calibrating;
        logic               enabled;
        logic               integrated;
    } t_heading_beat;

    // dut connections
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = FUNC_SAMPLE;
    logic signed [15:0] raw_rate = '0;
    logic [31:0]        time_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [33:0]        heading_out;
    logic signed [25:0] rate_out;
    logic               cal_out;
    logic               en_out;
    logic               integ_out;
    logic               cfg_we = 1'b0;
    logic               cfg_addr = CFG_MIN_INTERVAL;
    logic [15:0]        cfg_wdata = '0;

    // predicted block state
    bit          is_enabled;
    bit          in_calibration;
    int          bias_samples;
    int          bias_sum;
    int          bias_est;
    longint      heading_now;
    logic [31:0] last_stamp;
    logic [15:0] min_gap_ms = MIN_INTERVAL_RST;
    logic [9:0]  dt_cap_ms = MAX_DT_RST;

    // stimulus and scoreboard state
    t_heading_beat pending_headings[$];
    logic [31:0]   now_ms;
    bit            calm;
    bit            stall_request;
    int            errors;
    int            quiet_cycles;

    gyro_heading_integrator i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_func           (func),
        .i_raw_rate       (raw_rate),
        .i_time_ms        (time_ms),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_heading        (heading_out),
        .o_corrected_rate (rate_out),
        .o_calibrating    (cal_out),
        .o_enabled        (en_out),
        .o_integrated     (integ_out),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted outcome of one accepted beat, advancing the predicted state
    function automatic t_heading_beat integrate_beat(logic [1:0] f, logic signed [15:0] r,
                                                     logic [31:0] t);
        t_heading_beat res;
        longint        corrected;
        logic [31:0]   elapsed;
        longint        dt;
        corrected = longint'(r) * 256 - longint'(bias_est);
        res.integrated = 1'b0;
        case (f)
            FUNC_START: begin
                is_enabled = 1'b1;
                in_calibration = 1'b1;
                last_stamp = t;
                bias_samples = 0;
                bias_sum = 0;
            end
            FUNC_ZERO: heading_now = 0;
            FUNC_SAMPLE: begin
                if (is_enabled && in_calibration) begin
                    // collect bias, finish after the last sample of the set
                    bias_sum += int'(r);
                    bias_samples++;
                    if (bias_samples >= CAL_SAMPLES) begin
                        bias_est = bias_sum * (1 << (8 - CAL_LOG2_DEF));
                        heading_now = 0;
                        in_calibration = 1'b0;
                        bias_samples = 0;
                        bias_sum = 0;
                    end
                end else if (is_enabled) begin
                    elapsed = t - last_stamp;
                    if (elapsed >= min_gap_ms) begin
                        dt = (elapsed < dt_cap_ms) ? elapsed : dt_cap_ms;
                        heading_now = (heading_now + corrected * dt) % longint'(FULL_TURN);
                        if (heading_now < 0) heading_now += longint'(FULL_TURN);
                        last_stamp = t;
                        res.integrated = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.heading = heading_now[33:0];
        res.rate = corrected[25:0];
        res.calibrating = in_calibration;
        res.enabled = is_enabled;
        return res;
    endfunction

    // drive one input beat and wait for it to be taken
    task automatic send_item(logic [1:0] f, logic [15:0] r, logic [31:0] t);
        int gap;
        if (!calm && $urandom_range(0, 99) < 4) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        raw_rate <= r;
        time_ms <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_headings.push_back(integrate_beat(f, $signed(r), t));
    endtask

    // register write once the block has drained
    task automatic write_reg(logic idx, logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_headings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_INTERVAL) min_gap_ms = value;
        else dt_cap_ms = value[9:0];
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // time advance: mostly near the interval window, now and then a large jump
    function automatic logic [31:0] pick_step();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return $urandom_range(0, 1100);
        if (sel < 80) return $urandom_range(0, 2 * int'(min_gap_ms) + 2);
        if (sel < 95) return $urandom_range(0, 20);
        return $urandom;
    endfunction

    // start command followed by a full set of bias samples
    task automatic calibrate(t_cal_fill fill);
        logic [15:0] r;
        send_item(FUNC_START, pick_rate(), now_ms);
        repeat (CAL_SAMPLES) begin
            now_ms += $urandom_range(0, 20);
            case (fill)
                FILL_MAX: r = 16'h7FFF;
                FILL_MIN: r = 16'h8000;
                default:  r = pick_rate();
            endcase
            send_item(FUNC_SAMPLE, r, now_ms);
        end
    endtask

    task automatic run_phase(logic [15:0] min_gap, logic [9:0] cap, t_cal_fill fill,
                             int count);
        int kind;
        write_reg(CFG_MIN_INTERVAL, min_gap);
        write_reg(CFG_MAX_DT, {6'd0, cap});
        if (fill != FILL_NONE) calibrate(fill);
        repeat (count) begin
            kind = $urandom_range(0, 99);
            now_ms += pick_step();
            if (kind < 86) send_item(FUNC_SAMPLE, pick_rate(), now_ms);
            else if (kind < 93) send_item(FUNC_ZERO, pick_rate(), now_ms);
            else send_item(FUNC_UNUSED, pick_rate(), now_ms);
        end
    endtask

    // everything before the first start is ignored apart from zeroing
    task automatic test_disabled();
        send_item(FUNC_SAMPLE, 16'h7FFF, 32'd0);
        send_item(FUNC_SAMPLE, 16'h8000, 32'hFFFF_FFFF);
        send_item(FUNC_UNUSED, 16'h1234, 32'd100);
        send_item(FUNC_ZERO, 16'h0000, 32'd100);
    endtask

    // zero and unused codes during calibration, then a restart mid-set
    task automatic test_calibration_restart();
        send_item(FUNC_START, 16'h0000, 32'd1000);
        send_item(FUNC_SAMPLE, 16'd5, 32'd1001);
        send_item(FUNC_SAMPLE, -16'sd7, 32'd1002);
        send_item(FUNC_ZERO, 16'h0000, 32'd1003);
        send_item(FUNC_UNUSED, 16'h5555, 32'd1004);
        send_item(FUNC_START, 16'h0000, 32'd2000);
        send_item(FUNC_SAMPLE, 16'd9, 32'd2001);
    endtask

    // full calibration at the top rate, giving the largest positive bias
    task automatic test_calibration();
        now_ms = CAL_BASE_MS;
        calibrate(FILL_MAX);
    endtask

    // interval edges, saturation, wrap of the timestamp and register extremes
    task automatic test_integration();
        send_item(FUNC_SAMPLE, 16'h8000, CAL_BASE_MS + 32'd5);
        send_item(FUNC_SAMPLE, 16'h8000, CAL_BASE_MS + 32'd10);
        send_item(FUNC_SAMPLE, 16'h7FFF, CAL_BASE_MS + 32'd5010);
        send_item(FUNC_SAMPLE, 16'h0000, CAL_BASE_MS + 32'd5011);
        send_item(FUNC_ZERO, 16'h0000, CAL_BASE_MS + 32'd5012);
        send_item(FUNC_UNUSED, 16'hFFFF, CAL_BASE_MS + 32'd6000);
        send_item(FUNC_SAMPLE, -16'sd100, 32'hFFFF_FFF0);
        send_item(FUNC_SAMPLE, -16'sd100, 32'h0000_0005);
        // zero step cap: counts as integrated, heading stays
        write_reg(CFG_MAX_DT, 16'd0);
        send_item(FUNC_SAMPLE, 16'd1234, 32'd100);
        write_reg(CFG_MIN_INTERVAL, 16'd0);
        write_reg(CFG_MAX_DT, 16'd1023);
        send_item(FUNC_SAMPLE, 16'd500, 32'd100);
        send_item(FUNC_SAMPLE, 16'h8000, 32'd2100);
        write_reg(CFG_MIN_INTERVAL, 16'hFFFF);
        send_item(FUNC_SAMPLE, 16'd7, 32'd2200);
        send_item(FUNC_SAMPLE, 16'h8000, 32'd80000);
        now_ms = 32'd80000;
    endtask

    // receiver holds off while beats keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(CFG_MIN_INTERVAL, 16'd0);
        write_reg(CFG_MAX_DT, 16'd1000);
        stall_request = 1'b1;
        repeat (40) begin
            now_ms += $urandom_range(1, 50);
            send_item(FUNC_SAMPLE, pick_rate(), now_ms);
        end
    endtask

    task automatic test_random();
        run_phase(16'd10, 10'd1000, FILL_NONE, 15);
        run_phase(16'd0, 10'd1, FILL_NONE, 12);
        calm = 1'b1;
        run_phase(16'hFFFF, 10'd1023, FILL_NONE, 40);
        calm = 1'b0;
        run_phase(16'd0, 10'd0, FILL_NONE, 8);
        run_phase(16'd25, 10'd300, FILL_NONE, 18);
        run_phase(16'($urandom_range(0, 2000)), 10'($urandom_range(1, 1000)), FILL_NONE, 20);
        run_phase(16'($urandom), 10'($urandom), FILL_NONE, 15);
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled();
        test_calibration_restart();
        test_calibration();
        test_integration();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (pending_headings.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("gyro_heading_integrator test passed");
        else
            $display("gyro_heading_integrator test failed");
        $finish;
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!calm && $urandom_range(0, 99) < 10) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge clk) begin
        t_heading_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_headings.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, heading %0d", $time,
                         heading_out);
            end else begin
                want = pending_headings.pop_front();
                check_field("heading", want.heading, heading_out);
                check_field("corrected_rate", want.rate, rate_out);
                check_field("calibrating", want.calibrating, cal_out);
                check_field("enabled", want.enabled, en_out);
                check_field("integrated", want.integrated, integ_out);
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("gyro_heading_integrator test failed");
            $finish;
        end
    end

endmodule
